/* design/sscb_pkg.sv */
// ----------------------------------------------------------------------------
// sscb_pkg: shared types and constants for the scanline coverage bitmap
// Store geometry, action and register codes, controller/datapath
// interface structs, and the in-word range mask.
// ----------------------------------------------------------------------------
package sscb_pkg;

	localparam int WORDS = 33;
	localparam int AW    = $clog2(WORDS);
	localparam int NBITS = (WORDS - 1) * 32;
	localparam int PW    = $clog2(NBITS + 1);

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [1:0] REG_LINE_START = 2'd0;
	localparam logic [1:0] REG_LINE_END   = 2'd1;
	localparam logic [1:0] REG_INV_SCALE  = 2'd2;

	localparam logic signed [15:0] LINE_START_RST = 16'sd0;
	localparam logic signed [15:0] LINE_END_RST   = 16'sd1024;
	localparam logic        [15:0] INV_SCALE_RST  = 16'd4096;
	localparam logic signed [15:0] EXT_LOW_RST    = LINE_END_RST;
	localparam logic signed [15:0] EXT_HIGH_RST   = LINE_START_RST + 16'sd1;

	typedef struct packed {
		logic load;
		logic clear;
		logic mul;
		logic geo;
		logic clamp;
		logic sweep;
		logic rd;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
	} dp_stat_t;

	// bits [lo, hi) of the line that fall in word w, first bit in the MSB
	function automatic logic [31:0] span_mask(input logic [PW-1:0] lo,
		input logic [PW-1:0] hi, input logic [AW-1:0] w);
		logic signed [PW:0] base;
		logic signed [PW:0] lo_r;
		logic signed [PW:0] hi_r;
		logic [5:0] lo_c;
		logic [5:0] hi_c;
		base = $signed((PW+1)'({w, 5'b0}));
		lo_r = $signed({1'b0, lo}) - base;
		hi_r = $signed({1'b0, hi}) - base;
		if (lo_r < 0) lo_c = 6'd0;
		else if (lo_r > 32) lo_c = 6'd32;
		else lo_c = lo_r[5:0];
		if (hi_r < 0) hi_c = 6'd0;
		else if (hi_r > 32) hi_c = 6'd32;
		else hi_c = hi_r[5:0];
		return (ALL_ONES >> lo_c) & ~(ALL_ONES >> hi_c);
	endfunction

endpackage

/* design/scanline_span_coverage_bitmap.sv */
// ----------------------------------------------------------------------------
// scanline_span_coverage_bitmap: full/partial coverage maps for one scanline
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// One item is handled at a time; item_stall is high while it is in work.
// A clear passes through the clear state, a read through the read state
// and an unused action goes straight to the result state; an empty span
// ends after the multiply state. An add-span runs the setup states
// (multiply, floor/ceil, clamp), then one read-modify-write of the map RAM
// per word, a drain state and the result state. The single RAM read/write
// port pair sets the sweep length. A new item is accepted while the
// previous result still waits on result_stall.
// Configuration writes are always ready and must only be made while idle.
module scanline_span_coverage_bitmap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         action,
	input  logic signed [23:0] span_start,
	input  logic signed [23:0] span_end,
	input  logic               full_cover,
	input  logic [5:0]         word_index,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        full_word,
	output logic [31:0]        partial_word,
	output logic signed [15:0] touched_min,
	output logic signed [15:0] touched_max,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	import sscb_pkg::*;

	logic signed [15:0] line_start_q;
	logic signed [15:0] line_end_q;
	logic [15:0]        inv_scale_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= LINE_START_RST;
			line_end_q   <= LINE_END_RST;
			inv_scale_q  <= INV_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_START: line_start_q <= $signed(cfg_data);
				REG_LINE_END:   line_end_q   <= $signed(cfg_data);
				REG_INV_SCALE:  inv_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	sscb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	sscb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.line_start  (line_start_q),
		.line_end    (line_end_q),
		.inv_scale   (inv_scale_q),
		.action      (action),
		.span_start  (span_start),
		.span_end    (span_end),
		.full_cover  (full_cover),
		.word_index  (word_index),
		.full_word   (full_word),
		.partial_word(partial_word),
		.touched_min (touched_min),
		.touched_max (touched_max)
	);

endmodule

/* design/sscb_ram.sv */
// ----------------------------------------------------------------------------
// sscb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sscb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/sscb_ctrl.sv */
// ----------------------------------------------------------------------------
// sscb_ctrl: sequencing controller
// Steps each item through clear, span setup and word sweep, or read,
// and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module sscb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         action,
	output logic               result_valid,
	input  logic               result_stall,
	input  sscb_pkg::dp_stat_t stat,
	output sscb_pkg::dp_cmd_t  cmd
);

	import sscb_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_GEO  = 4'd3;
	localparam logic [3:0] S_CLP  = 4'd4;
	localparam logic [3:0] S_SWP  = 4'd5;
	localparam logic [3:0] S_DRN  = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       res_valid_q;
	logic       accept;
	logic       out_free;

	assign accept   = item_valid && (state_q == S_IDLE);
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (action)
						ACT_CLEAR: state_nxt = S_CLR;
						ACT_ADD:   state_nxt = S_MUL;
						ACT_READ:  state_nxt = S_RD;
						default:   state_nxt = S_FIN;
					endcase
				end
			end
			S_CLR: state_nxt = S_FIN;
			S_MUL: state_nxt = stat.empty ? S_FIN : S_GEO;
			S_GEO: state_nxt = S_CLP;
			S_CLP: state_nxt = S_SWP;
			S_SWP: begin
				if (stat.last) state_nxt = S_DRN;
			end
			S_DRN: state_nxt = S_FIN;
			S_RD:  state_nxt = S_FIN;
			S_FIN: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd.load     = accept;
		cmd.clear    = (state_q == S_CLR);
		cmd.mul      = (state_q == S_MUL);
		cmd.geo      = (state_q == S_GEO);
		cmd.clamp    = (state_q == S_CLP);
		cmd.sweep    = (state_q == S_SWP);
		cmd.rd       = (state_q == S_RD);
		cmd.out_load = (state_q == S_FIN) && out_free;
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_valid_q;

endmodule

/* design/sscb_dp.sv */
// ----------------------------------------------------------------------------
// sscb_dp: coverage bitmap datapath
// Line geometry and span scaling, word-by-word map update through the
// map RAM, extent tracking and the result register.
// ----------------------------------------------------------------------------
module sscb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sscb_pkg::dp_cmd_t   cmd,
	output sscb_pkg::dp_stat_t  stat,
	input  logic signed [15:0]  line_start,
	input  logic signed [15:0]  line_end,
	input  logic [15:0]         inv_scale,
	input  logic [1:0]          action,
	input  logic signed [23:0]  span_start,
	input  logic signed [23:0]  span_end,
	input  logic                full_cover,
	input  logic [5:0]          word_index,
	output logic [31:0]         full_word,
	output logic [31:0]         partial_word,
	output logic signed [15:0]  touched_min,
	output logic signed [15:0]  touched_max
);

	import sscb_pkg::*;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
		if (x > 17'sd32767) return 16'sd32767;
		else if (x < -17'sd32768) return -16'sd32768;
		else return x[15:0];
	endfunction

	function automatic logic [PW-1:0] clamp_rel(input logic signed [21:0] v,
		input logic signed [20:0] fb, input logic [PW-1:0] nb);
		logic signed [22:0] d;
		logic signed [22:0] nb_s;
		d    = 23'(v) - 23'(fb);
		nb_s = 23'(nb);
		if (d < 0) return '0;
		else if (d > nb_s) return nb;
		else return PW'(d);
	endfunction

	// latched item
	logic [1:0]         action_q;
	logic signed [23:0] span_start_q;
	logic signed [23:0] span_end_q;
	logic               full_cover_q;
	logic [5:0]         word_index_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q     <= action;
			span_start_q <= span_start;
			span_end_q   <= span_end;
			full_cover_q <= full_cover;
			word_index_q <= word_index;
		end
	end

	// line geometry from the registers
	logic signed [16:0] st_ext;
	logic signed [16:0] en_ext;
	logic signed [16:0] inv_ext;

	assign st_ext  = 17'(line_start);
	assign en_ext  = (line_end <= line_start) ? st_ext + 17'sd1 : 17'(line_end);
	assign inv_ext = $signed({1'b0, inv_scale});

	// multiply stage
	logic signed [32:0] p_st_s1;
	logic signed [33:0] p_en_s1;
	logic signed [40:0] p_sp_s1;
	logic signed [40:0] p_ep_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_st_s1 <= 33'(line_start) * 33'(inv_ext);
			p_en_s1 <= 34'(en_ext) * 34'(inv_ext);
			p_sp_s1 <= 41'(span_start_q) * 41'(inv_ext);
			p_ep_s1 <= 41'(span_end_q) * 41'(inv_ext);
		end
	end

	// floor / ceil stage
	logic signed [20:0] fb_c;
	logic signed [34:0] eb_sum;
	logic signed [22:0] eb_c;
	logic signed [23:0] nb_c;
	logic signed [41:0] sp_up;
	logic signed [41:0] ep_up;

	assign fb_c   = 21'(p_st_s1 >>> 12);
	assign eb_sum = 35'(p_en_s1) + 35'sd4095;
	assign eb_c   = 23'(eb_sum >>> 12);
	assign nb_c   = 24'(eb_c) - 24'(fb_c);
	assign sp_up  = 42'(p_sp_s1) + 42'sd1048575;
	assign ep_up  = 42'(p_ep_s1) + 42'sd1048575;

	logic signed [20:0] fb_s2;
	logic [PW-1:0]      nb_s2;
	logic signed [21:0] sfl_s2;
	logic signed [21:0] scl_s2;
	logic signed [21:0] efl_s2;
	logic signed [21:0] ecl_s2;

	always_ff @(posedge clk) begin
		if (cmd.geo) begin
			fb_s2  <= fb_c;
			nb_s2  <= (nb_c > 24'(NBITS)) ? PW'(NBITS) : PW'(nb_c);
			sfl_s2 <= 22'(p_sp_s1 >>> 20);
			scl_s2 <= 22'(sp_up >>> 20);
			efl_s2 <= 22'(p_ep_s1 >>> 20);
			ecl_s2 <= 22'(ep_up >>> 20);
		end
	end

	// clamp to the line, relative to its first bit
	logic [PW-1:0] fp_s3;
	logic [PW-1:0] lp_s3;
	logic [PW-1:0] ff_s3;
	logic [PW-1:0] lf_s3;

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			fp_s3 <= clamp_rel(sfl_s2, fb_s2, nb_s2);
			lp_s3 <= clamp_rel(ecl_s2, fb_s2, nb_s2);
			ff_s3 <= clamp_rel(scl_s2, fb_s2, nb_s2);
			lf_s3 <= clamp_rel(efl_s2, fb_s2, nb_s2);
		end
	end

	// touched extent
	logic signed [15:0] ext_low_q;
	logic signed [15:0] ext_high_q;
	logic signed [15:0] t_lo;
	logic signed [24:0] t_hi_sum;
	logic signed [16:0] t_hi;

	assign t_lo     = 16'(span_start_q >>> 8);
	assign t_hi_sum = 25'(span_end_q) + 25'sd255;
	assign t_hi     = 17'(t_hi_sum >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_low_q  <= EXT_LOW_RST;
			ext_high_q <= EXT_HIGH_RST;
		end else if (cmd.clear) begin
			ext_low_q  <= sat16(en_ext);
			ext_high_q <= sat16(st_ext + 17'sd1);
		end else if (cmd.clamp) begin
			if (t_lo < ext_low_q) ext_low_q <= t_lo;
			if (t_hi > 17'(ext_high_q)) ext_high_q <= sat16(t_hi);
		end
	end

	// word sweep: read word k, write it back in the following cycle
	logic [AW-1:0]    rd_idx_q;
	logic [AW-1:0]    wr_idx_s1;
	logic             wr_pend_s1;
	logic [WORDS-1:0] vld_q;
	logic [63:0]      rdata;
	logic [31:0]      old_full;
	logic [31:0]      old_part;
	logic [31:0]      m_p;
	logic [31:0]      m_f;
	logic [31:0]      new_full;
	logic [31:0]      new_part;
	logic             rd_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			wr_pend_s1 <= 1'b0;
			vld_q      <= '0;
		end else begin
			wr_pend_s1 <= cmd.sweep;
			if (cmd.clamp) rd_idx_q <= '0;
			else if (cmd.sweep) rd_idx_q <= rd_idx_q + 1'b1;
			if (cmd.clear) vld_q <= '0;
			else if (wr_pend_s1) vld_q[wr_idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		wr_idx_s1 <= rd_idx_q;
	end

	assign old_full = vld_q[wr_idx_s1] ? rdata[63:32] : '0;
	assign old_part = vld_q[wr_idx_s1] ? rdata[31:0] : '0;
	assign m_p      = span_mask(fp_s3, lp_s3, wr_idx_s1);
	assign m_f      = full_cover_q ? span_mask(ff_s3, lf_s3, wr_idx_s1) : '0;
	assign new_full = (old_full & ~m_p) | m_f;
	assign new_part = (old_part | m_p) & ~m_f;

	sscb_ram #(
		.WIDTH(64),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (wr_pend_s1),
		.waddr(wr_idx_s1),
		.wdata({new_full, new_part}),
		.re   (cmd.sweep | cmd.rd),
		.raddr(cmd.sweep ? rd_idx_q : AW'(word_index_q)),
		.rdata(rdata)
	);

	assign stat.empty = (span_start_q >= span_end_q);
	assign stat.last  = (rd_idx_q == AW'(WORDS - 1));

	// result register
	logic [31:0]        full_word_q;
	logic [31:0]        partial_word_q;
	logic signed [15:0] touched_min_q;
	logic signed [15:0] touched_max_q;

	assign rd_hit = (action_q == ACT_READ) && (int'(word_index_q) < WORDS)
		&& vld_q[AW'(word_index_q)];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			full_word_q    <= rd_hit ? rdata[63:32] : '0;
			partial_word_q <= rd_hit ? rdata[31:0] : '0;
			touched_min_q  <= (action_q == ACT_NONE) ? 16'sd0 : ext_low_q;
			touched_max_q  <= (action_q == ACT_NONE) ? 16'sd0 : ext_high_q;
		end
	end

	assign full_word    = full_word_q;
	assign partial_word = partial_word_q;
	assign touched_min  = touched_min_q;
	assign touched_max  = touched_max_q;

endmodule

/* design/sscb_checker.sv */
// ----------------------------------------------------------------------------
// sscb_checker: port-level checks for the scanline coverage bitmap
// Result handshake rules and item sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module sscb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic [31:0]        full_word,
	input logic [31:0]        partial_word,
	input logic signed [15:0] touched_min,
	input logic signed [15:0] touched_max
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(full_word) && $stable(partial_word)
			&& $stable(touched_min) && $stable(touched_max))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item not held busy after acceptance");

	a_no_early_res: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared the cycle after acceptance");

endmodule

bind scanline_span_coverage_bitmap sscb_checker u_sscb_checker (.*);
